/* hw/rtl/hsv2rgb_pkg.sv */
`default_nettype none

package hsv2rgb_pkg;

  // fixed-point grid: 1.0 = 2^FRAC_BITS
  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = FRAC_BITS + 1;   // unit-range values, 0..ONE
  localparam int HUE_W     = FRAC_BITS;
  localparam int H6_W      = FRAC_BITS + 3;   // hue * 6
  localparam int PROD_W    = 2 * VAL_W;

  // stream payload widths, rounded up to whole bytes
  localparam int IN_BITS   = HUE_W + 2 * VAL_W;
  localparam int OUT_BITS  = 3 * VAL_W;
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [VAL_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // hue sectors, 60 degrees each
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t                sector;
    logic [FRAC_BITS-1:0]   frac;
    logic [VAL_W-1:0]       sat;
    logic [VAL_W-1:0]       val;
  } prep_t;

  typedef struct packed {
    sector_t                sector;
    logic                   sat_zero;
    logic [VAL_W-1:0]       val;
    logic [VAL_W-1:0]       k_q;    // (s * f) >> FRAC_BITS
    logic [VAL_W-1:0]       k_t;    // (s * (1 - f)) >> FRAC_BITS
    logic [VAL_W-1:0]       p;
  } frac_t;

  typedef struct packed {
    sector_t                sector;
    logic                   sat_zero;
    logic [VAL_W-1:0]       val;
    logic [VAL_W-1:0]       p;
    logic [VAL_W-1:0]       q;
    logic [VAL_W-1:0]       t;
  } scale_t;

  typedef struct packed {
    logic [VAL_W-1:0]       blue;
    logic [VAL_W-1:0]       green;
    logic [VAL_W-1:0]       red;
  } rgb_t;

  // saturate a unit-range value to 1.0
  function automatic logic [VAL_W-1:0] clamp_unit(input logic [VAL_W-1:0] x);
    return (x > ONE) ? ONE : x;
  endfunction

  // (a * b) >> FRAC_BITS, result known to fit in VAL_W bits
  function automatic logic [VAL_W-1:0] fx_mul(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(a) * PROD_W'(b);
    return prod[FRAC_BITS+VAL_W-1:FRAC_BITS];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/hsv2rgb_prep.sv */
`default_nettype none

// stage 1: clamp, hue * 6 -> sector and in-sector fraction
module hsv2rgb_prep
  import hsv2rgb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [HUE_W-1:0] in_hue,
  input  wire logic [VAL_W-1:0] in_sat,
  input  wire logic [VAL_W-1:0] in_val,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output prep_t                 out_data
);

  logic             valid_r;
  prep_t            data_r;
  prep_t            data_nxt;
  logic [H6_W-1:0]  h6;

  always_comb begin
    h6                = (H6_W'(in_hue) << 2) + (H6_W'(in_hue) << 1);
    data_nxt.sector   = sector_t'(h6[H6_W-1:FRAC_BITS]);
    data_nxt.frac     = h6[FRAC_BITS-1:0];
    data_nxt.sat      = clamp_unit(in_sat);
    data_nxt.val      = clamp_unit(in_val);
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hsv2rgb_frac.sv */
`default_nettype none

// stage 2: saturation-weighted fractions and p
module hsv2rgb_frac
  import hsv2rgb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire prep_t  in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output frac_t       out_data
);

  logic   valid_r;
  frac_t  data_r;
  frac_t  data_nxt;

  always_comb begin
    data_nxt.sector   = in_data.sector;
    data_nxt.sat_zero = (in_data.sat == '0);
    data_nxt.val      = in_data.val;
    data_nxt.k_q      = fx_mul(in_data.sat, VAL_W'(in_data.frac));
    data_nxt.k_t      = fx_mul(in_data.sat, ONE - VAL_W'(in_data.frac));
    data_nxt.p        = fx_mul(in_data.val, ONE - in_data.sat);
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hsv2rgb_scale.sv */
`default_nettype none

// stage 3: q and t scaled by value
module hsv2rgb_scale
  import hsv2rgb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire frac_t  in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output scale_t      out_data
);

  logic    valid_r;
  scale_t  data_r;
  scale_t  data_nxt;

  always_comb begin
    data_nxt.sector   = in_data.sector;
    data_nxt.sat_zero = in_data.sat_zero;
    data_nxt.val      = in_data.val;
    data_nxt.p        = in_data.p;
    data_nxt.q        = fx_mul(in_data.val, ONE - in_data.k_q);
    data_nxt.t        = fx_mul(in_data.val, ONE - in_data.k_t);
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hsv2rgb_mux.sv */
`default_nettype none

// stage 4: per-sector channel routing, output register
module hsv2rgb_mux
  import hsv2rgb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire scale_t in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output rgb_t        out_data
);

  logic  valid_r;
  rgb_t  data_r;
  rgb_t  data_nxt;

  always_comb begin
    if (in_data.sat_zero) begin
      data_nxt = '{blue: in_data.val, green: in_data.val, red: in_data.val};
    end else begin
      case (in_data.sector)
        SEC_RED_YEL: data_nxt = '{red: in_data.val, green: in_data.t, blue: in_data.p};
        SEC_YEL_GRN: data_nxt = '{red: in_data.q, green: in_data.val, blue: in_data.p};
        SEC_GRN_CYN: data_nxt = '{red: in_data.p, green: in_data.val, blue: in_data.t};
        SEC_CYN_BLU: data_nxt = '{red: in_data.p, green: in_data.q, blue: in_data.val};
        SEC_BLU_MAG: data_nxt = '{red: in_data.t, green: in_data.p, blue: in_data.val};
        default:     data_nxt = '{red: in_data.val, green: in_data.p, blue: in_data.q};
      endcase
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hsv_to_rgb_convert_unit.sv */
`default_nettype none

// channel   dir  handshake             payload
// in_*      in   in_tvalid/in_tready   tdata: hue, saturation, brightness
// out_*     out  out_tvalid/out_tready tdata: red, green, blue
//
// Four register stages (prep, frac, scale, mux) from input transfer to result.
// One pixel per clock while unstalled; each stage's ready looks only at its own
// valid and the next stage's ready, so bubbles fill while the output stalls.
// The two 17x17 multiplier layers (fractions, then value scaling) set the
// stage depth. Synchronous active-low reset clears the valid bits only.
module hsv_to_rgb_convert_unit
  import hsv2rgb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // hue, saturation, brightness
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata   // red, green, blue
);

  logic   prep_valid, prep_ready;
  prep_t  prep_data;
  logic   frac_valid, frac_ready;
  frac_t  frac_data;
  logic   scale_valid, scale_ready;
  scale_t scale_data;
  rgb_t   rgb_data;

  hsv2rgb_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_hue    (in_tdata[HUE_W-1:0]),
    .in_sat    (in_tdata[HUE_W+VAL_W-1:HUE_W]),
    .in_val    (in_tdata[HUE_W+2*VAL_W-1:HUE_W+VAL_W]),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_data  (prep_data)
  );

  hsv2rgb_frac u_frac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_data   (prep_data),
    .out_valid (frac_valid),
    .out_ready (frac_ready),
    .out_data  (frac_data)
  );

  hsv2rgb_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (frac_valid),
    .in_ready  (frac_ready),
    .in_data   (frac_data),
    .out_valid (scale_valid),
    .out_ready (scale_ready),
    .out_data  (scale_data)
  );

  hsv2rgb_mux u_mux (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (scale_valid),
    .in_ready  (scale_ready),
    .in_data   (scale_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (rgb_data)
  );

  // red in the low bits, zero fill up to a whole byte
  assign out_tdata = OUT_W'(rgb_data);

endmodule

`default_nettype wire

/* tb/sv/hsv_to_rgb_convert_unit_tb.sv */
`default_nettype none

module hsv_to_rgb_convert_unit_tb;
  import hsv2rgb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_PIXELS = 1350;
  localparam int unsigned PRESSURE_AT   = 600;
  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned REPORT_MAX    = 10;

  // receiver back-pressure styles
  typedef enum int unsigned {
    RX_FREE,
    RX_RANDOM,
    RX_PERIODIC,
    RX_CHOKED
  } rx_style_t;

  // ------------------------------------------------------------------
  // expected-color store; prediction done per accepted pixel
  // ------------------------------------------------------------------
  class rgb_scoreboard;
    rgb_t        expected_q[$];
    int unsigned mismatches = 0;

    // fixed-point six-sector conversion, all products truncate
    function rgb_t predict_rgb(input logic [HUE_W-1:0] hue,
                               input logic [VAL_W-1:0] sat_in,
                               input logic [VAL_W-1:0] val_in);
      logic [63:0] unit, s, v, h6, f, p, q, t;
      sector_t     sec;
      rgb_t        c;
      unit = 64'd1 << FRAC_BITS;
      s    = (64'(sat_in) > unit) ? unit : 64'(sat_in);
      v    = (64'(val_in) > unit) ? unit : 64'(val_in);
      if (s == 0) begin
        c.red   = VAL_W'(v);
        c.green = VAL_W'(v);
        c.blue  = VAL_W'(v);
      end else begin
        h6  = 64'(hue) * 64'd6;
        sec = sector_t'(h6[FRAC_BITS+2:FRAC_BITS]);
        f   = h6 & (unit - 64'd1);
        p   = (v * (unit - s)) >> FRAC_BITS;
        q   = (v * (unit - ((s * f) >> FRAC_BITS))) >> FRAC_BITS;
        t   = (v * (unit - ((s * (unit - f)) >> FRAC_BITS))) >> FRAC_BITS;
        case (sec)
          SEC_RED_YEL: begin c.red = VAL_W'(v); c.green = VAL_W'(t); c.blue = VAL_W'(p); end
          SEC_YEL_GRN: begin c.red = VAL_W'(q); c.green = VAL_W'(v); c.blue = VAL_W'(p); end
          SEC_GRN_CYN: begin c.red = VAL_W'(p); c.green = VAL_W'(v); c.blue = VAL_W'(t); end
          SEC_CYN_BLU: begin c.red = VAL_W'(p); c.green = VAL_W'(q); c.blue = VAL_W'(v); end
          SEC_BLU_MAG: begin c.red = VAL_W'(t); c.green = VAL_W'(p); c.blue = VAL_W'(v); end
          default: begin c.red = VAL_W'(v); c.green = VAL_W'(p); c.blue = VAL_W'(q); end
        endcase
      end
      return c;
    endfunction

    function void note_pixel(input logic [HUE_W-1:0] hue,
                             input logic [VAL_W-1:0] sat,
                             input logic [VAL_W-1:0] val);
      expected_q.insert(expected_q.size(), predict_rgb(hue, sat, val));
    endfunction

    function void check_pixel(input logic [OUT_W-1:0] word);
      rgb_t got, want;
      got = rgb_t'(word[OUT_BITS-1:0]);
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected pixel: r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
        return;
      end
      want = expected_q[0];
      expected_q.delete(0);
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("pixel mismatch: exp r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   want.red, want.green, want.blue, got.red, got.green, got.blue);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;  // hue[15:0], saturation[32:16], brightness[49:33]
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;        // red[16:0], green[33:17], blue[50:34]

  rgb_scoreboard rgb_book = new();

  int unsigned burst_left = 0;
  rx_style_t   rx_style   = RX_FREE;
  int unsigned style_left = 0;
  int unsigned period_pos = 0;

  hsv_to_rgb_convert_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one pixel transfer; valid stays high into the next call for back-to-back bursts
  task automatic send_pixel(input logic [HUE_W-1:0] hue,
                            input logic [VAL_W-1:0] sat,
                            input logic [VAL_W-1:0] val);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({val, sat, hue});
    do @(posedge clk); while (!in_tready);
    rgb_book.note_pixel(hue, sat, val);
  endtask

  // bursts of random length, random idle gaps between them
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
      if (gap != 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // unit-range field, weighted toward the clamp and zero corners
  function automatic logic [VAL_W-1:0] pick_unit();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return ONE;
      2:       return ONE - 1'b1;
      3, 4:    return VAL_W'($urandom_range(65537, 131071));
      5:       return VAL_W'($urandom_range(1, 255));
      default: return VAL_W'($urandom_range(1, 65535));
    endcase
  endfunction

  // hue, sometimes right at a sector seam
  function automatic logic [HUE_W-1:0] pick_hue();
    int unsigned seam;
    if ($urandom_range(0, 7) == 0) begin
      seam = ($urandom_range(0, 5) * 65536 + 5) / 6;
      return HUE_W'(seam + $urandom_range(0, 4) - 2);
    end
    return HUE_W'($urandom_range(0, 65535));
  endfunction

  // receiver: switch style every so often
  always @(negedge clk) begin
    if (style_left == 0) begin
      rx_style   = rx_style_t'($urandom_range(0, 3));
      style_left = $urandom_range(20, 300);
    end
    style_left--;
    case (rx_style)
      RX_FREE:     out_tready <= 1'b1;
      RX_RANDOM:   out_tready <= ($urandom_range(0, 9) < 6);
      RX_PERIODIC: begin
        period_pos = (period_pos + 1) % 7;
        out_tready <= (period_pos < 4);
      end
      default:     out_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      rgb_book.check_pixel(out_tdata);
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: corners, sector seams, clamps, zero saturation
    pace_sender(); send_pixel(16'd0,     ONE,          ONE);
    pace_sender(); send_pixel(16'd65535, ONE,          ONE);
    pace_sender(); send_pixel(16'd0,     17'd0,        17'd0);
    pace_sender(); send_pixel(16'd12345, 17'd0,        17'd40000);
    pace_sender(); send_pixel(16'd50000, 17'd0,        17'd131071);
    pace_sender(); send_pixel(16'd30000, 17'd131071,   17'd131071);
    pace_sender(); send_pixel(16'd20000, 17'd65537,    17'd65537);
    pace_sender(); send_pixel(16'd40000, 17'd1,        17'd1);
    pace_sender(); send_pixel(16'd10922, ONE,          ONE);
    pace_sender(); send_pixel(16'd10923, ONE,          ONE);
    pace_sender(); send_pixel(16'd21845, ONE,          ONE);
    pace_sender(); send_pixel(16'd21846, ONE,          ONE);
    pace_sender(); send_pixel(16'd32767, 17'd50000,    ONE);
    pace_sender(); send_pixel(16'd32768, 17'd50000,    ONE);
    pace_sender(); send_pixel(16'd43690, 17'd30000,    17'd60000);
    pace_sender(); send_pixel(16'd43691, 17'd30000,    17'd60000);
    pace_sender(); send_pixel(16'd54613, ONE,          17'd777);
    pace_sender(); send_pixel(16'd54614, ONE,          17'd777);
    pace_sender(); send_pixel(16'd5000,  ONE - 17'd1,  ONE - 17'd1);
    pace_sender(); send_pixel(16'd60000, 17'd32768,    17'd0);
    pace_sender(); send_pixel(16'hAAAA,  17'h15555,    17'h0AAAA);
    pace_sender(); send_pixel(16'h5555,  17'h0AAAA,    17'h15555);

    for (int unsigned n = 0; n < RANDOM_PIXELS; n++) begin
      if (n == PRESSURE_AT) begin
        // hold off until the pipe has fully drained
        @(negedge clk);
        in_tvalid <= 1'b0;
        while (rgb_book.pending() != 0) @(posedge clk);
      end
      pace_sender();
      send_pixel(pick_hue(), pick_unit(), pick_unit());
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (rgb_book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (rgb_book.mismatches == 0 && rgb_book.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
